### hw/rtl/bsh_pkg.sv
// Package for the board-state hash set: sizes, opcodes and control/status types.
package bsh_pkg;

  // Table geometry; the table size must be a power of two (key = hash mod size).
  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned HASH_OUT_W = 10;

  // Hash constants
  localparam int unsigned   NUM_POS     = 6;
  localparam int unsigned   POS_W       = 7;
  localparam int unsigned   STEP_W      = $clog2(NUM_POS);
  localparam int unsigned   HASH_W      = 64;
  localparam logic [63:0]   HASH_GOLDEN = 64'h0000_0000_9e37_79b9;

  // Opcodes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;
  localparam opcode_t OP_UNUSED = 2'd3;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef pos_t [NUM_POS-1:0]       pos_arr_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture positions, clear hash
    logic hash;      // one hash round
    logic rd;        // read a slot
    logic rd_home;   // read address is the home slot (else the next slot)
    logic wr;        // write a slot
    logic wr_home;   // write address is the home slot (else the current slot)
    logic wr_occ;    // occupied flag to write
    logic clr;       // clear one slot of the sweep
    logic out_load;  // load the result register
    logic res_ins;
    logic res_rem;
  } bsh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hash_last;  // current hash round is the last one
    logic rd_occ;     // slot read is occupied
    logic rd_match;   // slot read holds the key
    logic next_home;  // next slot wraps back to home
    logic clr_last;   // sweep is at the last slot
  } bsh_sts_t;

endpackage

### hw/rtl/bsh_if.sv
// Item channel interfaces for the board-state hash set.
interface bsh_in_if;
  import bsh_pkg::*;
  logic     valid;
  logic     ready;
  opcode_t  opcode;
  pos_t     position_0;
  pos_t     position_1;
  pos_t     position_2;
  pos_t     position_3;
  pos_t     position_4;
  pos_t     position_5;

  modport source (output valid, opcode, position_0, position_1, position_2,
                  position_3, position_4, position_5, input ready);
  modport sink   (input valid, opcode, position_0, position_1, position_2,
                  position_3, position_4, position_5, output ready);
endinterface

interface bsh_out_if;
  logic       valid;
  logic       ready;
  logic       newly_inserted;
  logic       entry_removed;
  logic [9:0] hash_index;

  modport source (output valid, newly_inserted, entry_removed, hash_index,
                  input ready);
  modport sink   (input valid, newly_inserted, entry_removed, hash_index,
                  output ready);
endinterface

### hw/rtl/board_state_hash_set.sv
// Flow: an accepted item gets NUM_POS hash rounds; insert/remove then read the home
//   slot and probe on, one registered memory read per slot probed (up to TABLE_SIZE);
//   clear sweeps all TABLE_SIZE slots instead; then the result and out_item.valid load.
// Throughput: one item at a time; the next item can be accepted in the cycle after the
//   result is loaded, while that result may still wait in the output register.
// Reset (rst_n, synchronous): a sweep over all TABLE_SIZE slots empties the table;
//   in_item.ready stays low until it ends.
module board_state_hash_set (
  input logic       clk,
  input logic       rst_n,
  bsh_in_if.sink    in_item,
  bsh_out_if.source out_item
);
  import bsh_pkg::*;

  bsh_cmd_t  cmd;
  bsh_sts_t  sts;
  pos_arr_t  pos_in;

  // Gather the six positions
  assign pos_in[0] = in_item.position_0;
  assign pos_in[1] = in_item.position_1;
  assign pos_in[2] = in_item.position_2;
  assign pos_in[3] = in_item.position_3;
  assign pos_in[4] = in_item.position_4;
  assign pos_in[5] = in_item.position_5;

  bsh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .in_opcode (in_item.opcode),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bsh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .pos_in    (pos_in),
    .cmd       (cmd),
    .sts       (sts),
    .res_ins   (out_item.newly_inserted),
    .res_rem   (out_item.entry_removed),
    .res_index (out_item.hash_index)
  );

endmodule

### hw/rtl/bsh_datapath.sv
// Datapath: hash rounds, slot memory with probe addressing, clear sweep, result register.
module bsh_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  bsh_pkg::pos_arr_t  pos_in,
  input  bsh_pkg::bsh_cmd_t  cmd,
  output bsh_pkg::bsh_sts_t  sts,
  output logic               res_ins,
  output logic               res_rem,
  output logic [bsh_pkg::HASH_OUT_W-1:0] res_index
);
  import bsh_pkg::*;

  pos_arr_t           pos_r;
  logic [HASH_W-1:0]  h_r;
  logic [STEP_W-1:0]  step_r;
  idx_t               idx_r;
  logic [IDX_W:0]     rd_data_r;   // {occupied, key}
  idx_t               clr_r;
  logic               res_ins_r;
  logic               res_rem_r;
  logic [HASH_OUT_W-1:0] res_index_r;

  // Slot memory: occupied flag on top of the stored key
  logic [IDX_W:0] mem [TABLE_SIZE];

  idx_t               home;
  idx_t               idx_inc;
  idx_t               rd_addr;
  idx_t               wr_addr;
  logic [IDX_W:0]     wr_data;
  logic               wr_en;
  logic [HASH_W-1:0]  pos_ext;
  logic [HASH_W-1:0]  round_sum;

  assign home    = h_r[IDX_W-1:0];
  assign idx_inc = idx_r + idx_t'(1);
  assign rd_addr = cmd.rd_home ? home : idx_inc;

  // One hash round: h ^= p + golden + (h << 6) + (h >> 2)
  always_comb begin
    pos_ext   = {{(HASH_W-POS_W){pos_r[step_r][POS_W-1]}}, pos_r[step_r]};
    round_sum = pos_ext + HASH_GOLDEN + (h_r << 6) + (h_r >> 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
    end else if (cmd.hash) begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= pos_in;
      h_r   <= '0;
    end else if (cmd.hash) begin
      h_r <= h_r ^ round_sum;
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= (clr_r == idx_t'(TABLE_SIZE - 1)) ? '0 : clr_r + idx_t'(1);
    end
  end

  // Memory write port: sweep or probe update
  always_comb begin
    wr_en   = cmd.clr | cmd.wr;
    wr_addr = cmd.clr ? clr_r : (cmd.wr_home ? home : idx_r);
    wr_data = cmd.clr ? '0 : {cmd.wr_occ, home};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
      idx_r     <= rd_addr;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_ins_r   <= cmd.res_ins;
      res_rem_r   <= cmd.res_rem;
      res_index_r <= HASH_OUT_W'(home);
    end
  end

  assign sts.hash_last = (step_r == STEP_W'(NUM_POS - 1));
  assign sts.rd_occ    = rd_data_r[IDX_W];
  assign sts.rd_match  = (rd_data_r[IDX_W-1:0] == home);
  assign sts.next_home = (idx_inc == home);
  assign sts.clr_last  = (clr_r == idx_t'(TABLE_SIZE - 1));

  assign res_ins   = res_ins_r;
  assign res_rem   = res_rem_r;
  assign res_index = res_index_r;

endmodule

### hw/rtl/bsh_ctrl.sv
// Controller: sequences hashing, probing, clear sweeps and the result handshake.
module bsh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsh_pkg::opcode_t   in_opcode,
  output logic               out_valid,
  input  logic               out_ready,
  output bsh_pkg::bsh_cmd_t  cmd,
  input  bsh_pkg::bsh_sts_t  sts
);
  import bsh_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,   // sweep after reset
    ST_IDLE,
    ST_HASH,
    ST_ISSUE,  // read the home slot
    ST_PROBE,
    ST_CLEAR,  // sweep for a clear item
    ST_DONE
  } state_t;

  state_t   state_r, state_nxt;
  opcode_t  op_r, op_nxt;
  logic     ins_r, ins_nxt;
  logic     rem_r, rem_nxt;
  logic     out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ins_nxt       = ins_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.res_ins   = ins_r;
    cmd.res_rem   = rem_r;

    unique case (state_r)
      ST_INIT: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = in_opcode;
          ins_nxt   = 1'b0;
          rem_nxt   = 1'b0;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_last) begin
          case (op_r) inside
            OP_INSERT, OP_REMOVE: state_nxt = ST_ISSUE;
            OP_CLEAR:             state_nxt = ST_CLEAR;
            default:              state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.rd      = 1'b1;
        cmd.rd_home = 1'b1;
        state_nxt   = ST_PROBE;
      end
      ST_PROBE: begin
        if (!sts.rd_occ) begin
          // empty slot ends the walk
          if (op_r == OP_INSERT) begin
            cmd.wr     = 1'b1;
            cmd.wr_occ = 1'b1;
            ins_nxt    = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (sts.rd_match) begin
          // key found: duplicate for insert, free the slot for remove
          if (op_r == OP_REMOVE) begin
            cmd.wr     = 1'b1;
            cmd.wr_occ = 1'b0;
            rem_nxt    = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (sts.next_home) begin
          // full lap: insert overwrites the home slot
          if (op_r == OP_INSERT) begin
            cmd.wr      = 1'b1;
            cmd.wr_home = 1'b1;
            cmd.wr_occ  = 1'b1;
            ins_nxt     = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      op_r        <= OP_INSERT;
      ins_r       <= 1'b0;
      rem_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      ins_r       <= ins_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
